// File: hdl/emdf_pkg.sv
// shared types and constants for the escaped message deframer
// no dependencies; imported by emdf_core, emdf_out and the top level
package emdf_pkg;

    localparam int OVH_W     = 48;
    localparam int IV_VIEW_W = 96;
    localparam int IV_UP_W   = 32;
    localparam int IV_LO_W   = 64;
    localparam int CNT_W     = 2;

    localparam logic [OVH_W-1:0] OVH_MAX = {OVH_W{1'b1}};

    // byte codes that follow a full run of marker zeros
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_END  = 8'h01;
    localparam logic [7:0] BYTE_ESC  = 8'h02;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_IV   = 2'd2,
        KIND_ERR  = 2'd3
    } t_kind;

    // results of one stream byte: cnt-1 data zeros, then one result of kind
    typedef struct packed {
        logic [CNT_W-1:0]     cnt;
        t_kind                kind;
        logic [7:0]           payload;
        logic [IV_VIEW_W-1:0] iv;
        logic [OVH_W-1:0]     ovh;
    } t_result_bundle;

endpackage

// File: hdl/emdf_core.sv
// input register, deframer state and per-byte decode
// depends on emdf_pkg; feeds emdf_out with at most one result bundle per byte
module emdf_core import emdf_pkg::*; #(
    parameter int IV_BYTES     = 12,
    parameter int MARKER_ZEROS = 2,
    parameter int TAG_BYTES    = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [7:0]     i_stream_byte,
    output logic           o_res_load,
    output t_result_bundle o_res,
    input  logic           i_res_ready
);

    localparam int IV_W = 8 * IV_BYTES;
    localparam int IC_W = $clog2(IV_BYTES + 1);
    localparam int PZ_W = $clog2(MARKER_ZEROS + 1);

    localparam logic [IC_W-1:0]  IC_FULL  = IC_W'(IV_BYTES);
    localparam logic [PZ_W-1:0]  PZ_FULL  = PZ_W'(MARKER_ZEROS);
    localparam logic [CNT_W-1:0] CNT_RUN  = CNT_W'(MARKER_ZEROS);
    localparam logic [OVH_W-1:0] OVH_IV   = OVH_W'(IV_BYTES);
    localparam logic [OVH_W-1:0] OVH_ESC  = OVH_W'(1);
    localparam logic [OVH_W-1:0] OVH_END  = OVH_W'(MARKER_ZEROS + 1 + TAG_BYTES);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_collected, n_collected;
    logic [IC_W-1:0]   r_iv_cnt, n_iv_cnt;
    logic [IV_W-1:0]   r_iv, n_iv;
    logic [PZ_W-1:0]   r_pend, n_pend;
    logic              r_err, n_err;
    logic [OVH_W-1:0]  r_ovh, n_ovh;

    logic [OVH_W-1:0]  ovh_inc;
    logic [OVH_W:0]    ovh_sum;
    logic [CNT_W-1:0]  res_cnt;
    t_kind             res_kind;
    logic [7:0]        res_payload;
    logic [IV_VIEW_W-1:0] iv_view;
    logic              adv;
    logic              accept;

    // decode of the byte in the input register against current state
    always_comb begin
        n_collected = r_collected;
        n_iv_cnt    = r_iv_cnt;
        n_iv        = r_iv;
        n_pend      = r_pend;
        n_err       = r_err;
        ovh_inc     = '0;
        res_cnt     = '0;
        res_kind    = KIND_DATA;
        res_payload = '0;
        if (r_err) begin
            res_cnt  = CNT_W'(1);
            res_kind = KIND_ERR;
        end else if (!r_collected) begin
            // first stream byte lands in the most significant iv byte
            for (int k = 0; k < IV_BYTES; k++) begin
                if (r_iv_cnt == IC_W'(k)) begin
                    n_iv[8*(IV_BYTES-1-k) +: 8] = r_in_byte;
                end
            end
            n_iv_cnt = r_iv_cnt + IC_W'(1);
            if (n_iv_cnt == IC_FULL) begin
                n_collected = 1'b1;
                ovh_inc     = OVH_IV;
                res_cnt     = CNT_W'(1);
                res_kind    = KIND_IV;
            end
        end else if (r_pend == PZ_FULL) begin
            case (r_in_byte)
                BYTE_ESC: begin
                    n_pend  = '0;
                    ovh_inc = OVH_ESC;
                    res_cnt = CNT_RUN;
                end
                BYTE_END: begin
                    n_pend   = '0;
                    ovh_inc  = OVH_END;
                    n_iv     = r_iv + IV_W'(1);
                    res_cnt  = CNT_W'(1);
                    res_kind = KIND_END;
                end
                BYTE_ZERO: begin
                    res_cnt = CNT_W'(1);
                end
                default: begin
                    n_pend   = '0;
                    n_err    = 1'b1;
                    res_cnt  = CNT_W'(1);
                    res_kind = KIND_ERR;
                end
            endcase
        end else if (r_in_byte == BYTE_ZERO) begin
            n_pend = r_pend + PZ_W'(1);
        end else begin
            res_cnt     = CNT_W'(r_pend) + CNT_W'(1);
            res_payload = r_in_byte;
            n_pend      = '0;
        end
    end

    // saturating overhead count
    always_comb begin
        ovh_sum = {1'b0, r_ovh} + {1'b0, ovh_inc};
        n_ovh   = ovh_sum[OVH_W] ? OVH_MAX : ovh_sum[OVH_W-1:0];
    end

    if (IV_W >= IV_VIEW_W) begin : g_iv_trunc
        assign iv_view = n_iv[IV_VIEW_W-1:0];
    end else begin : g_iv_ext
        assign iv_view = {{(IV_VIEW_W-IV_W){1'b0}}, n_iv};
    end

    assign adv     = r_in_valid && ((res_cnt == '0) || i_res_ready);
    assign o_stall = r_in_valid && !adv;
    assign accept  = i_valid && !o_stall;

    assign o_res_load  = adv && (res_cnt != '0);
    assign o_res.cnt     = res_cnt;
    assign o_res.kind    = res_kind;
    assign o_res.payload = res_payload;
    assign o_res.iv      = iv_view;
    assign o_res.ovh     = n_ovh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_collected <= 1'b0;
            r_iv_cnt    <= '0;
            r_pend      <= '0;
            r_err       <= 1'b0;
            r_ovh       <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_collected <= n_collected;
                r_iv_cnt    <= n_iv_cnt;
                r_pend      <= n_pend;
                r_err       <= n_err;
                r_ovh       <= n_ovh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_stream_byte;
        end
        if (adv) begin
            r_iv <= n_iv;
        end
    end

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("framing error flag cleared without reset");

    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PZ_FULL)
        else $error("pending zero count above marker length");

    a_iv_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_collected |-> (r_iv_cnt == IC_FULL) && (r_pend == '0 || r_pend <= PZ_FULL))
        else $error("iv marked collected with a partial byte count");

endmodule

// File: hdl/emdf_out.sv
// result register: plays out one bundle as a run of result transactions
// depends on emdf_pkg; loaded by emdf_core
module emdf_out import emdf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_res_load,
    input  t_result_bundle       i_res,
    output logic                 o_res_ready,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_kind,
    output logic [7:0]           o_payload_byte,
    output logic [IV_UP_W-1:0]   o_iv_upper,
    output logic [IV_LO_W-1:0]   o_iv_lower,
    output logic [OVH_W-1:0]     o_overhead_total,
    output logic                 o_last_of_run
);

    logic                 r_valid;
    logic [CNT_W-1:0]     r_rem;
    t_kind                r_kind;
    logic [7:0]           r_payload;
    logic [IV_VIEW_W-1:0] r_iv;
    logic [OVH_W-1:0]     r_ovh;
    logic                 last;
    logic                 take;
    t_kind                kind_now;

    assign last        = (r_rem == CNT_W'(1));
    assign take        = r_valid && !i_stall;
    assign o_res_ready = !r_valid || (last && !i_stall);

    // leading results of a run are data zeros
    assign kind_now         = last ? r_kind : KIND_DATA;
    assign o_valid          = r_valid;
    assign o_kind           = kind_now;
    assign o_payload_byte   = last ? r_payload : 8'h00;
    assign o_iv_upper       = r_iv[IV_VIEW_W-1 -: IV_UP_W];
    assign o_iv_lower       = r_iv[IV_LO_W-1:0];
    assign o_overhead_total = r_ovh;
    assign o_last_of_run    = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rem   <= '0;
        end else begin
            if (i_res_load) begin
                r_valid <= 1'b1;
                r_rem   <= i_res.cnt;
            end else if (take) begin
                if (last) begin
                    r_valid <= 1'b0;
                    r_rem   <= '0;
                end else begin
                    r_rem <= r_rem - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_load) begin
            r_kind    <= i_res.kind;
            r_payload <= i_res.payload;
            r_iv      <= i_res.iv;
            r_ovh     <= i_res.ovh;
        end
    end

    a_rem_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_rem != '0))
        else $error("result register valid with an empty run");

    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_load |-> o_res_ready)
        else $error("bundle loaded over a run still in flight");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && last && !i_res_load) |=> !r_valid)
        else $error("result register still valid after its last transaction");

endmodule

// File: hdl/escaped_message_deframer_with_iv.sv
// top level of the escaped message deframer with iv capture
// depends on emdf_pkg, emdf_core and emdf_out
//
// One stream byte is taken per transaction and the block sustains one byte per
// clock while the result side keeps up. A byte passes an input register, is
// decoded combinationally against the deframer state and lands as a bundle in
// the result register, which plays it out as one result transaction per clock
// unless the receiver stalls. Bytes that give no result (iv bytes before the
// last, pending zeros) leave the input register without touching the result
// side. A byte that gives several results (pending zeros ahead of a data byte,
// or an escaped zero run) holds the result register until all are taken, and a
// following byte that has results waits in the input register meanwhile, which
// stalls the input side. A framing error is sticky until reset.
module escaped_message_deframer_with_iv import emdf_pkg::*; #(
    parameter int IV_BYTES     = 12,
    parameter int MARKER_ZEROS = 2,
    parameter int TAG_BYTES    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_stream_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_payload_byte,
    output logic [IV_UP_W-1:0] o_iv_upper,
    output logic [IV_LO_W-1:0] o_iv_lower,
    output logic [OVH_W-1:0]   o_overhead_total,
    output logic               o_last_of_run
);

    t_result_bundle res;
    logic           res_load;
    logic           res_ready;

    emdf_core #(
        .IV_BYTES     (IV_BYTES),
        .MARKER_ZEROS (MARKER_ZEROS),
        .TAG_BYTES    (TAG_BYTES)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_stream_byte (i_stream_byte),
        .o_res_load    (res_load),
        .o_res         (res),
        .i_res_ready   (res_ready)
    );

    emdf_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_res_load       (res_load),
        .i_res            (res),
        .o_res_ready      (res_ready),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_payload_byte   (o_payload_byte),
        .o_iv_upper       (o_iv_upper),
        .o_iv_lower       (o_iv_lower),
        .o_overhead_total (o_overhead_total),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

// File: verif/escaped_message_deframer_with_iv_test.sv
// self-checking testbench for the escaped message deframer with iv capture
// depends on emdf_pkg and the escaped_message_deframer_with_iv top level
module escaped_message_deframer_with_iv_test import emdf_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IV_LEN       = 12;
    localparam int ZERO_RUN     = 2;
    localparam int TAG_LEN      = 16;
    localparam int RANDOM_BYTES = 750;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 80;
    localparam int QUIET_LO     = 400;
    localparam int QUIET_HI     = 550;
    localparam int DOG_LIMIT    = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        t_kind                kind;
        logic [7:0]           payload;
        logic [IV_UP_W-1:0]   iv_up;
        logic [IV_LO_W-1:0]   iv_lo;
        logic [OVH_W-1:0]     ovh;
        logic                 last;
    } t_frame_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_stream_byte = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_kind;
    logic [7:0]         o_payload_byte;
    logic [IV_UP_W-1:0] o_iv_upper;
    logic [IV_LO_W-1:0] o_iv_lower;
    logic [OVH_W-1:0]   o_overhead_total;
    logic               o_last_of_run;

    escaped_message_deframer_with_iv #(
        .IV_BYTES    (IV_LEN),
        .MARKER_ZEROS(ZERO_RUN),
        .TAG_BYTES   (TAG_LEN)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_stream_byte   (i_stream_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_payload_byte  (o_payload_byte),
        .o_iv_upper      (o_iv_upper),
        .o_iv_lower      (o_iv_lower),
        .o_overhead_total(o_overhead_total),
        .o_last_of_run   (o_last_of_run)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // deframer state as predicted
    logic                 iv_done = 1'b0;
    int                   iv_count = 0;
    logic [IV_VIEW_W-1:0] iv_acc = '0;
    int                   zeros_held = 0;
    logic                 sticky_err = 1'b0;
    logic [OVH_W-1:0]     ovh_count = '0;

    t_frame_result expected_results[$];
    logic [7:0]    byte_backlog[$];

    int accepted_bytes = 0;
    int mismatches = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    wire  hold_active = (hold_left != 0);
    wire  quiet = (accepted_bytes >= QUIET_LO) && (accepted_bytes < QUIET_HI);

    // generator side tracking of pending zeros, keeps sequences clean of errors
    int gen_count = 0;
    int gen_zeros = 0;

    function automatic t_frame_result frame_result(t_kind k, logic [7:0] p);
        t_frame_result r;
        r.kind    = k;
        r.payload = p;
        r.iv_up   = iv_acc[IV_VIEW_W-1:IV_LO_W];
        r.iv_lo   = iv_acc[IV_LO_W-1:0];
        r.ovh     = ovh_count;
        r.last    = 1'b0;
        return r;
    endfunction

    task automatic add_overhead(input int n);
        logic [OVH_W:0] sum;
        sum = {1'b0, ovh_count} + (OVH_W+1)'(n);
        ovh_count = (sum > {1'b0, OVH_MAX}) ? OVH_MAX : sum[OVH_W-1:0];
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        t_frame_result r[ZERO_RUN];
        int n;
        n = 0;
        if (sticky_err) begin
            r[n] = frame_result(KIND_ERR, 8'h00); n++;
        end else if (!iv_done) begin
            iv_acc = {iv_acc[IV_VIEW_W-9:0], b};
            iv_count++;
            if (iv_count >= IV_LEN) begin
                iv_done = 1'b1;
                add_overhead(IV_LEN);
                r[n] = frame_result(KIND_IV, 8'h00); n++;
            end
        end else if (zeros_held >= ZERO_RUN) begin
            if (b == BYTE_ESC) begin
                zeros_held = 0;
                add_overhead(1);
                for (int i = 0; i < ZERO_RUN; i++) begin
                    r[n] = frame_result(KIND_DATA, 8'h00); n++;
                end
            end else if (b == BYTE_END) begin
                zeros_held = 0;
                add_overhead(ZERO_RUN + 1);
                add_overhead(TAG_LEN);
                iv_acc = iv_acc + 1'b1;
                r[n] = frame_result(KIND_END, 8'h00); n++;
            end else if (b == BYTE_ZERO) begin
                r[n] = frame_result(KIND_DATA, 8'h00); n++;
            end else begin
                zeros_held = 0;
                sticky_err = 1'b1;
                r[n] = frame_result(KIND_ERR, 8'h00); n++;
            end
        end else if (b == BYTE_ZERO) begin
            zeros_held++;
        end else begin
            for (int i = 0; i < zeros_held; i++) begin
                r[n] = frame_result(KIND_DATA, 8'h00); n++;
            end
            zeros_held = 0;
            r[n] = frame_result(KIND_DATA, b); n++;
        end
        for (int i = 0; i < n; i++) begin
            r[i].last = (i == n - 1);
            expected_results.push_back(r[i]);
        end
    endtask

    // queue a byte, steering any byte after a full zero run away from the error case
    task automatic queue_byte(input logic [7:0] b);
        logic [7:0] v;
        v = b;
        if (gen_count >= IV_LEN) begin
            if (gen_zeros >= ZERO_RUN) begin
                if (v > BYTE_ESC)
                    v = 8'($urandom_range(0, 2));
                if (v != BYTE_ZERO)
                    gen_zeros = 0;
            end else if (v == BYTE_ZERO) begin
                gen_zeros++;
            end else begin
                gen_zeros = 0;
            end
        end
        byte_backlog.push_back(v);
        gen_count++;
    endtask

    task automatic queue_marker(input logic [7:0] code);
        while (gen_zeros < ZERO_RUN)
            queue_byte(BYTE_ZERO);
        queue_byte(code);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stream_byte <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                deframe_byte(i_stream_byte);
                accepted_bytes <= accepted_bytes + 1;
            end
            if (!i_valid || !o_stall) begin
                if (byte_backlog.size() > 0 && (quiet || $urandom_range(0, 99) >= 6)) begin
                    i_valid <= 1'b1;
                    i_stream_byte <= byte_backlog.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off once, so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && accepted_bytes == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_frame_result e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind %0d payload %h", o_kind,
                                 o_payload_byte);
                end else begin
                    e = expected_results.pop_front();
                    if (o_kind !== e.kind || o_payload_byte !== e.payload ||
                        o_iv_upper !== e.iv_up || o_iv_lower !== e.iv_lo ||
                        o_overhead_total !== e.ovh || o_last_of_run !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("expected kind %0d payload %h iv %h_%h ovh %h last %b",
                                     e.kind, e.payload, e.iv_up, e.iv_lo, e.ovh, e.last);
                            $display("actual   kind %0d payload %h iv %h_%h ovh %h last %b",
                                     o_kind, o_payload_byte, o_iv_upper, o_iv_lower,
                                     o_overhead_total, o_last_of_run);
                        end
                    end
                end
            end
            i_stall <= hold_active || (!quiet && $urandom_range(0, 99) < 6);
        end
    end

    // watchdog on cycles with no transaction on either side
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= DOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int pick;
        int total_bytes;
        // all-ones iv so that the first message end wraps it to zero
        repeat (IV_LEN) queue_byte(8'hFF);
        // message end with no data
        queue_marker(BYTE_END);
        queue_byte(8'hFF);
        queue_byte(8'h80);
        queue_byte(8'h7F);
        // single zero ahead of a plain escape code byte
        queue_byte(BYTE_ZERO);
        queue_byte(BYTE_ESC);
        queue_marker(BYTE_ESC);
        // zero arriving on a full run, then message end
        queue_byte(BYTE_ZERO);
        queue_byte(BYTE_ZERO);
        queue_byte(BYTE_ZERO);
        queue_byte(BYTE_END);

        while (gen_count < IV_LEN + 16 + RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                queue_byte(8'($urandom_range(1, 255)));
            else if (pick < 65)
                queue_byte(BYTE_ZERO);
            else if (pick < 75)
                queue_marker(BYTE_ESC);
            else if (pick < 83)
                queue_marker(BYTE_END);
            else
                queue_byte(8'($urandom_range(0, 255)));
        end

        // broken marker at the very end: the error is sticky
        while (gen_zeros < ZERO_RUN)
            queue_byte(BYTE_ZERO);
        byte_backlog.push_back(8'($urandom_range(3, 255)));
        repeat (6) byte_backlog.push_back(8'($urandom_range(0, 255)));
        total_bytes = byte_backlog.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every byte accepted means every expected result is queued
        while (accepted_bytes < total_bytes)
            @(posedge i_clk);
        while (expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
